FILE: sv/nsr_pkg.sv
package nsr_pkg;

  localparam int RAD_W         = 32;
  localparam int ROOT_W        = 24;
  localparam int TOL_W         = 16;
  localparam int MAX_ITER_DEF  = 40;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [ROOT_W-1:0] ROOT_MAX  = '1;
  localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
    logic emit;
  } nsr_cmd_t;

  typedef struct packed {
    logic rad_zero;
    logic conv;
  } nsr_status_t;

endpackage

FILE: sv/nsr_ctrl.sv
module nsr_ctrl #(
  parameter int MAX_ITER  = nsr_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                busy,
  input  logic                out_stall,
  output logic                out_valid,
  input  nsr_pkg::nsr_status_t status,
  output nsr_pkg::nsr_cmd_t   cmd
);
  import nsr_pkg::*;

  localparam int NW  = RAD_W + FRAC_BITS;
  localparam int NWP = NW + (NW % 2);
  localparam int DC  = NWP / 2;
  localparam int DCW = $clog2(DC + 1);
  localparam int IW  = $clog2(MAX_ITER + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [IW-1:0]  iter_r, iter_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    dcnt_nxt      = dcnt_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          state_nxt = status.rad_zero ? S_FIN : S_INIT;
        end
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = DCW'(DC - 1);
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r - DCW'(1);
        if (dcnt_r == '0) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        iter_nxt   = iter_r + IW'(1);
        if (status.conv || iter_r == IW'(MAX_ITER - 1)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dcnt_r      <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dcnt_r      <= dcnt_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/nsr_dp.sv
module nsr_dp #(
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [nsr_pkg::RAD_W-1:0]   in_radicand,
  input  logic [nsr_pkg::TOL_W-1:0]   tolerance,
  input  nsr_pkg::nsr_cmd_t           cmd,
  output nsr_pkg::nsr_status_t        status,
  output logic [nsr_pkg::ROOT_W-1:0]  out_root,
  output logic                        out_converged
);
  import nsr_pkg::*;

  localparam int NW  = RAD_W + FRAC_BITS;
  localparam int NWP = NW + (NW % 2);

  logic [RAD_W-1:0]  a_r;
  logic [NW-1:0]     x_r;
  logic [NW-1:0]     d_r;
  logic [NW-1:0]     rem_r;
  logic [NWP-1:0]    nq_r;
  logic              conv_r;
  logic [ROOT_W-1:0] root_r;
  logic              rconv_r;

  logic [NW:0]   sh0, sh1, dext;
  logic          b0, b1;
  logic [NW-1:0] r0, r1;
  logic [NW:0]   sum;
  logic [NW-1:0] nx, diff;
  logic          conv;

  assign dext = {1'b0, d_r};

  always_comb begin
    sh0 = {rem_r, nq_r[NWP-1]};
    b0  = (sh0 >= dext);
    r0  = b0 ? NW'(sh0 - dext) : sh0[NW-1:0];
    sh1 = {r0, nq_r[NWP-2]};
    b1  = (sh1 >= dext);
    r1  = b1 ? NW'(sh1 - dext) : sh1[NW-1:0];
  end

  always_comb begin
    sum  = {1'b0, x_r} + {1'b0, nq_r[NW-1:0]};
    nx   = sum[NW:1];
    diff = (nx >= x_r) ? (nx - x_r) : (x_r - nx);
    conv = (diff < NW'(tolerance));
  end

  assign status.rad_zero = (in_radicand == '0);
  assign status.conv     = conv;
  assign out_root        = root_r;
  assign out_converged   = rconv_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= in_radicand;
      x_r    <= NW'(in_radicand);
      conv_r <= (in_radicand == '0);
    end
    if (cmd.div_init) begin
      nq_r  <= NWP'(a_r) << FRAC_BITS;
      d_r   <= (x_r == '0) ? NW'(1) : x_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= r1;
      nq_r  <= {nq_r[NWP-3:0], b0, b1};
    end
    if (cmd.update) begin
      conv_r <= conv;
      if (!conv) begin
        x_r <= nx;
      end
    end
    if (cmd.emit) begin
      root_r  <= (x_r > NW'(ROOT_MAX)) ? ROOT_MAX : x_r[ROOT_W-1:0];
      rconv_r <= conv_r;
    end
  end

endmodule

FILE: sv/newton_square_root.sv
// Channel | Direction | Handshake        | Payload
// in_     | input     | in_valid/in_stall  | in_radicand[31:0]
// out_    | output    | out_valid/out_stall| out_root[23:0], out_converged
// cfg_    | input     | cfg_valid/cfg_ready| cfg_tolerance[15:0]
//
// One item at a time. Each Newton step initialises and runs the shared radix-2 divider,
// which retires two quotient bits per cycle, then updates the estimate.
// An item takes at most MAX_ITER steps (40 by default); a zero radicand skips them.
// Synchronous active-low reset clears control and sets tolerance to 1.
// The next item is taken while a finished result waits on out_stall.
module newton_square_root #(
  parameter int MAX_ITER  = nsr_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [nsr_pkg::RAD_W-1:0]  in_radicand,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [nsr_pkg::ROOT_W-1:0] out_root,
  output logic                       out_converged,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nsr_pkg::TOL_W-1:0]  cfg_tolerance
);
  import nsr_pkg::*;

  logic [TOL_W-1:0] tol_r;
  nsr_cmd_t         cmd;
  nsr_status_t      status;
  logic             busy;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_tolerance;
    end
  end

  nsr_ctrl #(
    .MAX_ITER  (MAX_ITER),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .busy      (busy),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  nsr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .in_radicand   (in_radicand),
    .tolerance     (tol_r),
    .cmd           (cmd),
    .status        (status),
    .out_root      (out_root),
    .out_converged (out_converged)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after input transfer");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("block still busy after issuing result");

  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_radicand == '0 && !out_valid) |=> ##1 out_valid)
    else $error("zero radicand not returned at once");
`endif

endmodule
